/* rtl/core/sla_pkg.sv */
// sla_pkg: shared widths, register indexes and reset values for the
// semi-Lagrangian advection block. No dependencies.
package sla_pkg;

  // grid geometry default
  localparam int GRID_SIDE_DEF = 256;

  // field widths
  localparam int IDX_W        = 8;
  localparam int VAL_W        = 32;
  localparam int STEP_SCALE_W = 24;
  localparam int SIZE_W       = 8;
  localparam int FRAC_W       = 16;
  localparam int COORD_W      = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SCALE    = 1'b0,
    CFG_INTERIOR_SIZE = 1'b1
  } cfg_reg_t;

  // register reset values
  localparam logic [STEP_SCALE_W-1:0] STEP_SCALE_RST    = 24'd278528;
  localparam logic [SIZE_W-1:0]       INTERIOR_SIZE_RST = 8'd254;

  // one half in Q16.16
  localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;

endpackage

/* rtl/core/sla_ram.sv */
// sla_ram: generic single-write, single-read RAM with registered,
// read-first output. No dependencies.
module sla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read port returns old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/semi_lagrangian_advection.sv */
// semi_lagrangian_advection: top level, nine-stage pipeline with the grid
// store split into four parity banks. Depends on sla_pkg and sla_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall   | kind, row, col, cell_value, vel
//  out_    | output    | out_valid/out_stall | out_row, out_col, out_value
//  cfg_    | input     | cfg_wr_en           | cfg_index, cfg_data
//
// One request per clock unless out_stall fills the pipeline; an accepted advect
// request passes stages 1 to 8 and the output register. Four banks (row parity x
// column parity) give all four bilinear neighbours in a single read.
// Loads write the store at the read stage, so later advects see them in order.
// Reset clears the valid bits and the configuration registers; the store and payload registers are not cleared.
// A stage holds while the one after it is full and held; bubbles collapse.
module semi_lagrangian_advection #(
  parameter int GRID_SIDE = sla_pkg::GRID_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_wr_en,
  input  logic [sla_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sla_pkg::CFG_DATA_W-1:0]         cfg_data,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_kind,
  input  logic [sla_pkg::IDX_W-1:0]              in_row,
  input  logic [sla_pkg::IDX_W-1:0]              in_col,
  input  logic signed [sla_pkg::VAL_W-1:0]       in_cell_value,
  input  logic signed [sla_pkg::VAL_W-1:0]       in_vel_row,
  input  logic signed [sla_pkg::VAL_W-1:0]       in_vel_col,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sla_pkg::IDX_W-1:0]              out_row,
  output logic [sla_pkg::IDX_W-1:0]              out_col,
  output logic signed [sla_pkg::VAL_W-1:0]       out_value
);

  import sla_pkg::*;

  // bank geometry
  localparam int BANK_SIDE  = (GRID_SIDE + 1) / 2;
  localparam int HB         = $clog2(BANK_SIDE);
  localparam int BANK_DEPTH = 1 << (2 * HB);

  // datapath widths
  localparam int PROD_W  = 57;
  localparam int DISP_W  = 41;
  localparam int PNT_W   = 58;
  localparam int DIFF_W  = 33;
  localparam int BLEND_W = 50;
  localparam int DLU_W   = 51;
  localparam int PPL_W   = 41;
  localparam int PPH_W   = 43;
  localparam int ACC_W   = 68;
  localparam int RES_W   = 36;

  localparam logic signed [PROD_W-1:0] RND16    = {{(PROD_W-16){1'b0}}, 16'h8000};
  localparam logic signed [PNT_W-1:0]  LO_CLAMP = {{(PNT_W-FRAC_W){1'b0}}, HALF_Q16};
  localparam logic signed [ACC_W-1:0]  RND32    = {{(ACC_W-32){1'b0}}, 32'h8000_0000};
  localparam logic signed [RES_W-1:0]  SAT_MAX  = {4'h0, 32'h7FFF_FFFF};
  localparam logic signed [RES_W-1:0]  SAT_MIN  = {4'hF, 32'h8000_0000};

  // traced coordinate: (idx << 16) - round(prod >> 16), clamped
  function automatic logic [COORD_W-1:0] trace_coord(
    input logic [IDX_W-1:0]         idx,
    input logic signed [PROD_W-1:0] prod,
    input logic [SIZE_W-1:0]        n
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [DISP_W-1:0] disp;
    logic signed [PNT_W-1:0]  p;
    logic signed [PNT_W-1:0]  hi;
    rnd  = prod + RND16;
    disp = DISP_W'(rnd >>> 16);
    p    = $signed({{(PNT_W-IDX_W-FRAC_W){1'b0}}, idx, {FRAC_W{1'b0}}}) - PNT_W'(disp);
    hi   = $signed({{(PNT_W-SIZE_W-FRAC_W){1'b0}}, n, HALF_Q16});
    if (p < LO_CLAMP) begin
      p = LO_CLAMP;
    end else if (p > hi) begin
      p = hi;
    end
    return p[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------
  // configuration registers
  logic [STEP_SCALE_W-1:0] step_scale_r;
  logic [SIZE_W-1:0]       interior_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_scale_r    <= STEP_SCALE_RST;
      interior_size_r <= INTERIOR_SIZE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STEP_SCALE:    step_scale_r    <= cfg_data[STEP_SCALE_W-1:0];
        CFG_INTERIOR_SIZE: interior_size_r <= cfg_data[SIZE_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------
  // stage valids and load enables
  logic st1_valid_r, st2_valid_r, st3_valid_r, st4_valid_r;
  logic st5_valid_r, st6_valid_r, st7_valid_r, st8_valid_r;
  logic out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en_out;

  assign en_out = !out_valid_r || !out_stall;
  assign en8    = !st8_valid_r || en_out;
  assign en7    = !st7_valid_r || en8;
  assign en6    = !st6_valid_r || en7;
  assign en5    = !st5_valid_r || en6;
  assign en4    = !st4_valid_r || en5;
  assign en3    = !st3_valid_r || en4;
  assign en2    = !st2_valid_r || en3;
  assign en1    = !st1_valid_r || en2;
  assign in_stall = !en1;

  // stage 1: backtrace products
  logic                      st1_kind_r;
  logic [IDX_W-1:0]          st1_row_r, st1_col_r;
  logic signed [VAL_W-1:0]   st1_value_r;
  logic signed [PROD_W-1:0]  st1_prod_row_r, st1_prod_col_r;
  logic signed [PROD_W-1:0]  prod_row_nxt, prod_col_nxt;

  assign prod_row_nxt = $signed({1'b0, step_scale_r}) * in_vel_row;
  assign prod_col_nxt = $signed({1'b0, step_scale_r}) * in_vel_col;

  // stage 2: clamped coordinates
  logic                      st2_kind_r;
  logic [IDX_W-1:0]          st2_row_r, st2_col_r;
  logic signed [VAL_W-1:0]   st2_value_r;
  logic [COORD_W-1:0]        st2_x_r, st2_y_r;
  logic [COORD_W-1:0]        x_nxt, y_nxt;

  assign x_nxt = trace_coord(st1_row_r, st1_prod_row_r, interior_size_r);
  assign y_nxt = trace_coord(st1_col_r, st1_prod_col_r, interior_size_r);

  // stage 2 -> 3: bank addressing, neighbour masks, store writes
  logic [IDX_W-1:0] i0, j0;
  logic [IDX_W:0]   i1, j1;
  logic [3:0]       nb_ok_nxt;
  logic             ok_r0, ok_r1, ok_c0, ok_c1;
  logic             ram_we;
  logic [31:0]      wrow_half, wcol_half;
  logic [2*HB-1:0]  ram_waddr;
  logic [VAL_W-1:0] bank_q [4];

  assign i0 = st2_x_r[COORD_W-1:FRAC_W];
  assign j0 = st2_y_r[COORD_W-1:FRAC_W];
  assign i1 = {1'b0, i0} + 1'b1;
  assign j1 = {1'b0, j0} + 1'b1;

  // a neighbour off the grid reads as zero
  assign ok_r0 = 32'(i0) < GRID_SIDE;
  assign ok_r1 = 32'(i1) < GRID_SIDE;
  assign ok_c0 = 32'(j0) < GRID_SIDE;
  assign ok_c1 = 32'(j1) < GRID_SIDE;
  assign nb_ok_nxt = {ok_r1 & ok_c1, ok_r1 & ok_c0, ok_r0 & ok_c1, ok_r0 & ok_c0};

  // load leaves stage 2 into the store; off-grid loads are dropped
  assign ram_we = st2_valid_r && !st2_kind_r && en3 &&
                  (32'(st2_row_r) < GRID_SIDE) && (32'(st2_col_r) < GRID_SIDE);
  assign wrow_half = 32'(st2_row_r >> 1);
  assign wcol_half = 32'(st2_col_r >> 1);
  assign ram_waddr = {wrow_half[HB-1:0], wcol_half[HB-1:0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BPR = 1'((b >> 1) & 1);
    localparam logic BPC = 1'(b & 1);
    logic [IDX_W:0]  rd_row, rd_col;
    logic [31:0]     rrow_half, rcol_half;
    logic [2*HB-1:0] raddr;
    logic            we_b;

    // each bank holds exactly one of the four neighbours
    assign rd_row    = (i0[0] == BPR) ? {1'b0, i0} : i1;
    assign rd_col    = (j0[0] == BPC) ? {1'b0, j0} : j1;
    assign rrow_half = 32'(rd_row >> 1);
    assign rcol_half = 32'(rd_col >> 1);
    assign raddr     = {rrow_half[HB-1:0], rcol_half[HB-1:0]};
    assign we_b      = ram_we && (st2_row_r[0] == BPR) && (st2_col_r[0] == BPC);

    sla_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (we_b),
      .waddr (ram_waddr),
      .wdata (st2_value_r),
      .re    (en3),
      .raddr (raddr),
      .rdata (bank_q[b])
    );
  end

  // stage 3: bank data, fractions, parities
  logic [IDX_W-1:0]  st3_row_r, st3_col_r;
  logic [FRAC_W-1:0] st3_fr_r, st3_fc_r;
  logic              st3_pr_r, st3_pc_r;
  logic [3:0]        st3_ok_r;

  // stage 3 -> 4: route banks to neighbours, column differences
  logic signed [VAL_W-1:0]  nb_a, nb_b, nb_c, nb_d;
  logic signed [DIFF_W-1:0] db_nxt, dc_nxt;

  assign nb_a = st3_ok_r[0] ? $signed(bank_q[{st3_pr_r, st3_pc_r}])   : '0;
  assign nb_b = st3_ok_r[1] ? $signed(bank_q[{st3_pr_r, !st3_pc_r}])  : '0;
  assign nb_c = st3_ok_r[2] ? $signed(bank_q[{!st3_pr_r, st3_pc_r}])  : '0;
  assign nb_d = st3_ok_r[3] ? $signed(bank_q[{!st3_pr_r, !st3_pc_r}]) : '0;
  assign db_nxt = DIFF_W'(nb_b) - DIFF_W'(nb_a);
  assign dc_nxt = DIFF_W'(nb_d) - DIFF_W'(nb_c);

  // stage 4
  logic [IDX_W-1:0]         st4_row_r, st4_col_r;
  logic [FRAC_W-1:0]        st4_fr_r, st4_fc_r;
  logic signed [VAL_W-1:0]  st4_a_r, st4_c_r;
  logic signed [DIFF_W-1:0] st4_db_r, st4_dc_r;

  // stage 4 -> 5: row blends, t0*a + t1*b = (a << 16) + t1*(b - a)
  logic signed [BLEND_W-1:0] lo_nxt, up_nxt;

  assign lo_nxt = $signed({{2{st4_a_r[VAL_W-1]}}, st4_a_r, {FRAC_W{1'b0}}}) +
                  $signed({1'b0, st4_fc_r}) * st4_db_r;
  assign up_nxt = $signed({{2{st4_c_r[VAL_W-1]}}, st4_c_r, {FRAC_W{1'b0}}}) +
                  $signed({1'b0, st4_fc_r}) * st4_dc_r;

  // stage 5
  logic [IDX_W-1:0]          st5_row_r, st5_col_r;
  logic [FRAC_W-1:0]         st5_fr_r;
  logic signed [BLEND_W-1:0] st5_lo_r, st5_up_r;

  // stage 6: vertical difference
  logic [IDX_W-1:0]          st6_row_r, st6_col_r;
  logic [FRAC_W-1:0]         st6_fr_r;
  logic signed [BLEND_W-1:0] st6_lo_r;
  logic signed [DLU_W-1:0]   st6_dlu_r;

  // stage 6 -> 7: s1 * (up - lo) as two partial products
  logic [PPL_W-1:0]        ppl_nxt;
  logic signed [PPH_W-1:0] pph_nxt;

  assign ppl_nxt = st6_fr_r * st6_dlu_r[24:0];
  assign pph_nxt = $signed({1'b0, st6_fr_r}) * $signed(st6_dlu_r[DLU_W-1:25]);

  // stage 7
  logic [IDX_W-1:0]          st7_row_r, st7_col_r;
  logic signed [BLEND_W-1:0] st7_lo_r;
  logic [PPL_W-1:0]          st7_ppl_r;
  logic signed [PPH_W-1:0]   st7_pph_r;

  // stage 7 -> 8: exact Q32.32 blend
  logic signed [ACC_W-1:0] acc_nxt;

  assign acc_nxt = $signed({{2{st7_lo_r[BLEND_W-1]}}, st7_lo_r, {FRAC_W{1'b0}}}) +
                   $signed({st7_pph_r, 25'd0}) +
                   $signed({{(ACC_W-PPL_W){1'b0}}, st7_ppl_r});

  // stage 8
  logic [IDX_W-1:0]        st8_row_r, st8_col_r;
  logic signed [ACC_W-1:0] st8_acc_r;

  // stage 8 -> out: round once, saturate
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RES_W-1:0] res;
  logic                    sat_hi, sat_lo;
  logic signed [VAL_W-1:0] value_nxt;

  assign acc_rnd = st8_acc_r + RND32;
  assign res     = $signed(acc_rnd[ACC_W-1:32]);
  assign sat_hi  = res > SAT_MAX;
  assign sat_lo  = res < SAT_MIN;

  always_comb begin
    if (sat_hi) begin
      value_nxt = 32'sh7FFF_FFFF;
    end else if (sat_lo) begin
      value_nxt = 32'sh8000_0000;
    end else begin
      value_nxt = res[VAL_W-1:0];
    end
  end

  // output register
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [VAL_W-1:0] out_value_r;

  // ---------------------------------------------------------------
  // valid bits; loads drop out after the store stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
      st2_valid_r <= 1'b0;
      st3_valid_r <= 1'b0;
      st4_valid_r <= 1'b0;
      st5_valid_r <= 1'b0;
      st6_valid_r <= 1'b0;
      st7_valid_r <= 1'b0;
      st8_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    st1_valid_r <= in_valid;
      if (en2)    st2_valid_r <= st1_valid_r;
      if (en3)    st3_valid_r <= st2_valid_r && st2_kind_r;
      if (en4)    st4_valid_r <= st3_valid_r;
      if (en5)    st5_valid_r <= st4_valid_r;
      if (en6)    st6_valid_r <= st5_valid_r;
      if (en7)    st7_valid_r <= st6_valid_r;
      if (en8)    st8_valid_r <= st7_valid_r;
      if (en_out) out_valid_r <= st8_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      st1_kind_r     <= in_kind;
      st1_row_r      <= in_row;
      st1_col_r      <= in_col;
      st1_value_r    <= in_cell_value;
      st1_prod_row_r <= prod_row_nxt;
      st1_prod_col_r <= prod_col_nxt;
    end
    if (en2) begin
      st2_kind_r  <= st1_kind_r;
      st2_row_r   <= st1_row_r;
      st2_col_r   <= st1_col_r;
      st2_value_r <= st1_value_r;
      st2_x_r     <= x_nxt;
      st2_y_r     <= y_nxt;
    end
    if (en3) begin
      st3_row_r <= st2_row_r;
      st3_col_r <= st2_col_r;
      st3_fr_r  <= st2_x_r[FRAC_W-1:0];
      st3_fc_r  <= st2_y_r[FRAC_W-1:0];
      st3_pr_r  <= i0[0];
      st3_pc_r  <= j0[0];
      st3_ok_r  <= nb_ok_nxt;
    end
    if (en4) begin
      st4_row_r <= st3_row_r;
      st4_col_r <= st3_col_r;
      st4_fr_r  <= st3_fr_r;
      st4_fc_r  <= st3_fc_r;
      st4_a_r   <= nb_a;
      st4_c_r   <= nb_c;
      st4_db_r  <= db_nxt;
      st4_dc_r  <= dc_nxt;
    end
    if (en5) begin
      st5_row_r <= st4_row_r;
      st5_col_r <= st4_col_r;
      st5_fr_r  <= st4_fr_r;
      st5_lo_r  <= lo_nxt;
      st5_up_r  <= up_nxt;
    end
    if (en6) begin
      st6_row_r <= st5_row_r;
      st6_col_r <= st5_col_r;
      st6_fr_r  <= st5_fr_r;
      st6_lo_r  <= st5_lo_r;
      st6_dlu_r <= DLU_W'(st5_up_r) - DLU_W'(st5_lo_r);
    end
    if (en7) begin
      st7_row_r <= st6_row_r;
      st7_col_r <= st6_col_r;
      st7_lo_r  <= st6_lo_r;
      st7_ppl_r <= ppl_nxt;
      st7_pph_r <= pph_nxt;
    end
    if (en8) begin
      st8_row_r <= st7_row_r;
      st8_col_r <= st7_col_r;
      st8_acc_r <= acc_nxt;
    end
    if (en_out) begin
      out_row_r   <= st8_row_r;
      out_col_r   <= st8_col_r;
      out_value_r <= value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

  // ---------------------------------------------------------------
  // a load request never turns into a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    st2_valid_r && !st2_kind_r && en3 |=> !st3_valid_r)
    else $error("load request reached the blend stages");

  // advect requests keep their cell index across the store stage
  a_advect_carries_index: assert property (@(posedge clk) disable iff (!rst_n)
    st2_valid_r && st2_kind_r && en3 |=> st3_valid_r && (st3_row_r == $past(st2_row_r)))
    else $error("advect request lost across the store stage");

  // traced coordinate lies inside the clamp window
  a_coord_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    st2_valid_r && st2_kind_r |->
      (st2_x_r >= COORD_W'(HALF_Q16)) && (st2_x_r <= {interior_size_r, HALF_Q16}))
    else $error("row coordinate outside clamp window");

  // input only held back while stages 1 and 2 are occupied
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> st1_valid_r && st2_valid_r)
    else $error("request stalled with room in the pipeline");

  // the blend is convex, so the rounded value never saturates
  a_blend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st8_valid_r |-> !sat_hi && !sat_lo)
    else $error("bilinear blend left the 32-bit range");

endmodule

/* tb/semi_lagrangian_advection_tb.sv */
// Testbench for semi_lagrangian_advection: drives load and advect requests, predicts every
// advected cell from its own copy of the grid and registers. Depends on sla_pkg and the RTL.
`timescale 1ns / 1ps

module semi_lagrangian_advection_tb;
  import sla_pkg::*;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_ADVECT = 1'b1;
  localparam int   CYCLE_LIMIT   = 1_000_000;
  localparam int   LONG_HOLD     = 300;
  localparam int   SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } advected_cell_t;

  // Grid copy, register copy and queue of advected cells still owed by the block
  class advection_scoreboard;
    bit signed [31:0] field [65536];
    logic [23:0]      scale;
    logic [7:0]       size;
    advected_cell_t   expected_q[$];
    int               errors;
    int               checked;
    int               loads_seen;

    function new();
      scale = STEP_SCALE_RST;
      size  = INTERIOR_SIZE_RST;
    endfunction

    function void set_register(cfg_reg_t idx, logic [23:0] data);
      if (idx == CFG_STEP_SCALE) scale = data;
      else size = data[7:0];
    endfunction

    // Backtraced coordinate in Q16.16, clamped to [0.5, size + 0.5]
    function longint trace(logic [7:0] idx, logic signed [31:0] vel);
      longint disp, p, top;
      disp = (longint'(scale) * longint'(vel) + 64'sd32768) >>> 16;
      p    = (longint'(idx) <<< 16) - disp;
      top  = (longint'(size) <<< 16) + 64'sd32768;
      if (p < 64'sd32768) p = 64'sd32768;
      if (p > top) p = top;
      return p;
    endfunction

    // cells past the grid edge read as zero
    function longint cell_at(longint r, longint c);
      if (r > 255 || c > 255) return 0;
      return longint'(field[int'(r) * 256 + int'(c)]);
    endfunction

    function void note_request(logic kind, logic [7:0] row, logic [7:0] col,
                               logic signed [31:0] value, logic signed [31:0] vr,
                               logic signed [31:0] vc);
      longint x, y, i0, j0, s0, s1, t0, t1, lo, up, acc, v;
      advected_cell_t owed;
      if (kind == KIND_LOAD) begin
        field[{row, col}] = value;
        loads_seen++;
        return;
      end
      x  = trace(row, vr);
      y  = trace(col, vc);
      i0 = x >>> 16;
      j0 = y >>> 16;
      s1 = x & 64'sd65535;
      t1 = y & 64'sd65535;
      s0 = 64'sd65536 - s1;
      t0 = 64'sd65536 - t1;
      lo  = t0 * cell_at(i0, j0) + t1 * cell_at(i0, j0 + 1);
      up  = t0 * cell_at(i0 + 1, j0) + t1 * cell_at(i0 + 1, j0 + 1);
      acc = s0 * lo + s1 * up;
      v   = (acc + 64'sd2147483648) >>> 32;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      owed.row   = row;
      owed.col   = col;
      owed.value = v[31:0];
      expected_q.push_back(owed);
    endfunction

    function void check_result(logic [7:0] row, logic [7:0] col, logic signed [31:0] value);
      advected_cell_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result for cell (%0d,%0d) with no advect request outstanding", row, col);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (row !== want.row) begin
        errors++;
        $error("out_row: expected %0d, got %0d", want.row, row);
      end
      if (col !== want.col) begin
        errors++;
        $error("out_col: expected %0d, got %0d", want.col, col);
      end
      if (value !== want.value) begin
        errors++;
        $error("out_value: expected %0d, got %0d", want.value, value);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = 1'b0;
  logic [IDX_W-1:0]     in_row = '0;
  logic [IDX_W-1:0]     in_col = '0;
  logic signed [VAL_W-1:0] in_cell_value = '0;
  logic signed [VAL_W-1:0] in_vel_row = '0;
  logic signed [VAL_W-1:0] in_vel_col = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     out_row;
  logic [IDX_W-1:0]     out_col;
  logic signed [VAL_W-1:0] out_value;

  advection_scoreboard sb = new();
  bit cell_loaded [65536];
  int items_sent;
  int settings_run;
  int cycle_count;
  bit send_calm;
  bit recv_calm;
  int holds_asked;
  int holds_done;
  int hold_left;
  int stall_left;
  int run_left;

  semi_lagrangian_advection DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_cell_value(in_cell_value),
    .in_vel_row   (in_vel_row),
    .in_vel_col   (in_vel_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short idle runs, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Velocity: mostly one that lands near the grid, some extremes and raw noise
  function automatic logic signed [31:0] pick_velocity();
    longint d, v, reach;
    int sel;
    sel   = $urandom_range(0, 99);
    reach = longint'(sb.size) + 3;
    if (sel < 10) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        3: return 32'sd1;
        default: return -32'sd1;
      endcase
    end
    if (sel < 30 || sb.scale == 0) return $urandom;
    d = longint'($urandom_range(0, int'(2 * reach * 65536))) - reach * 65536;
    v = (d * 65536) / longint'(sb.scale);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Receiver: random stall runs, free runs, and a long hold when one is asked for
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_calm) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (run_left != 0) begin
      run_left  <= run_left - 1;
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
      run_left   <= $urandom_range(1, 12);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_row, out_col, out_value);
  end

  // One request: optional idle gap, then hold it until accepted
  task automatic send_item(logic kind, logic [7:0] row, logic [7:0] col,
                           logic signed [31:0] value, logic signed [31:0] vr,
                           logic signed [31:0] vc);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_row        <= row;
    in_col        <= col;
    in_cell_value <= value;
    in_vel_row    <= vr;
    in_vel_col    <= vc;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, row, col, value, vr, vc);
    items_sent++;
  endtask

  task automatic send_load(logic [7:0] row, logic [7:0] col, logic signed [31:0] value);
    cell_loaded[{row, col}] = 1'b1;
    send_item(KIND_LOAD, row, col, value, $urandom, $urandom);
  endtask

  // Advect, first loading any stencil cell not yet written
  task automatic send_advect(logic [7:0] row, logic [7:0] col,
                             logic signed [31:0] vr, logic signed [31:0] vc);
    int x, y, r, c;
    x = int'(sb.trace(row, vr) >>> 16);
    y = int'(sb.trace(col, vc) >>> 16);
    for (r = x; r <= x + 1; r++)
      for (c = y; c <= y + 1; c++)
        if (r < 256 && c < 256 && !cell_loaded[r * 256 + c])
          send_load(r[7:0], c[7:0], pick_value());
    send_item(KIND_ADVECT, row, col, $urandom, vr, vc);
  endtask

  task automatic send_random_item();
    int span;
    logic [7:0] row, col;
    span = (sb.size == 8'd255) ? 255 : sb.size + 1;
    if ($urandom_range(0, 99) < 30) begin
      if ($urandom_range(0, 1))
        send_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_value());
      else
        send_load(8'($urandom_range(0, span)), 8'($urandom_range(0, span)), pick_value());
    end else begin
      if (sb.size == 0 || $urandom_range(0, 99) < 15) begin
        row = 8'($urandom_range(0, 255));
        col = 8'($urandom_range(0, 255));
      end else begin
        row = 8'($urandom_range(1, sb.size));
        col = 8'($urandom_range(1, sb.size));
      end
      send_advect(row, col, pick_velocity(), pick_velocity());
    end
  endtask

  // Drop valid, wait out every advected cell, then let trailing loads settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [23:0] scale, logic [7:0] size, int count, bit calm);
    int stop_at;
    wait_idle();
    write_reg(CFG_STEP_SCALE, scale);
    write_reg(CFG_INTERIOR_SIZE, {16'd0, size});
    settings_run++;
    send_calm = calm;
    recv_calm = calm;
    stop_at   = items_sent + count;
    while (items_sent < stop_at) send_random_item();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme cell values on both clamp corners, clamps from both sides,
    // boundary and non-interior cells, small fractional steps
    settings_run = 1;
    send_load(8'd0, 8'd0, 32'sh7FFF_FFFF);
    send_load(8'd0, 8'd1, 32'sh8000_0000);
    send_load(8'd1, 8'd0, 32'sh8000_0000);
    send_load(8'd1, 8'd1, 32'sh7FFF_FFFF);
    send_load(8'd254, 8'd254, -32'sd1);
    send_load(8'd254, 8'd255, 32'sh8000_0000);
    send_load(8'd255, 8'd254, 32'sd1);
    send_load(8'd255, 8'd255, 32'sh7FFF_FFFF);
    send_advect(8'd3, 8'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_advect(8'd3, 8'd3, 32'sh8000_0000, 32'sh8000_0000);
    send_advect(8'd0, 8'd0, 32'sd0, 32'sd0);
    send_advect(8'd255, 8'd255, 32'sd0, 32'sd0);
    send_advect(8'd255, 8'd0, 32'sd0, 32'sd0);
    send_advect(8'd10, 8'd20, 32'sh0000_4000, -32'sh0000_4000);
    send_advect(8'd128, 8'd128, 32'sd1, -32'sd1);
    send_advect(8'd1, 8'd1, 32'sh0000_1E1E, 32'sh0000_0F0F);

    // interior size zero collapses the clamp; widest scale and size reach off the grid
    run_phase(24'h01_0000, 8'd0, 100, 1'b0);
    run_phase(24'hFF_FFFF, 8'd255, 150, 1'b0);
    run_phase(24'h00_0000, 8'd17, 80, 1'b1);
    run_phase(24'($urandom_range(24'h00_4000, 24'h08_0000)), 8'd6, 400, 1'b0);

    // Back-pressure: receiver holds off while requests keep coming, then the
    // sender pauses until the block has drained
    send_calm = 1'b1;
    holds_asked++;
    repeat (60) send_random_item();
    send_calm = 1'b0;
    wait_idle();

    run_phase(STEP_SCALE_RST, INTERIOR_SIZE_RST, 300, 1'b0);
    run_phase(24'($urandom_range(1, 24'h0F_FFFF)), 8'($urandom_range(1, 40)), 400, 1'b0);
    run_phase(24'($urandom_range(0, 24'hFF_FFFF)), 8'($urandom_range(0, 255)), 200, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) $error("%0d advected cells never came out", sb.pending());
    $display("Sent %0d requests (%0d loads) under %0d register settings; checked %0d cells.",
             items_sent, sb.loads_seen, settings_run, sb.checked);
    $display("Mismatches: %0d, cycles used: %0d", sb.errors, cycle_count);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
